// ===== design/rfa_pkg.sv =====
package rfa_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 16;
   localparam int RES_NUM_WIDTH = 32;
   localparam int RES_DEN_WIDTH = 30;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SETUP,
      ST_GCD,
      ST_DIVN_START,
      ST_DIVN_WAIT,
      ST_DIVD_START,
      ST_DIVD_WAIT,
      ST_DONE
   } state_type;

endpackage

// ===== design/rfa_if.sv =====
interface rfa_req_if #(parameter int W = rfa_pkg::OPERAND_WIDTH_DEFAULT);
   logic valid;
   logic ready;
   logic [1:0] action;
   logic signed [W-1:0] a_num;
   logic [W-2:0] a_den;
   logic signed [W-1:0] b_num;
   logic [W-2:0] b_den;
   modport source(output valid, action, a_num, a_den, b_num, b_den, input ready);
   modport sink(input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_rsp_if;
   logic valid;
   logic ready;
   logic signed [rfa_pkg::RES_NUM_WIDTH-1:0] res_num;
   logic [rfa_pkg::RES_DEN_WIDTH-1:0] res_den;
   logic status;
   modport source(output valid, res_num, res_den, status, input ready);
   modport sink(input valid, res_num, res_den, status, output ready);
endinterface

// ===== design/rfa_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module rfa_divider #(parameter int N = 32) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [N-1:0] divisor,
   output logic [N-1:0] quotient,
   output logic         done
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff, quo_in;
   logic [N:0]    rem_ff, rem_in;
   logic [N-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [N:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[N-1:0], quo_ff[N-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

// ===== design/rational_fraction_alu_unit.sv =====
// Channel   Direction  Contents
// req       in         action, a_num, a_den, b_num, b_den
// rsp       out        res_num, res_den, status
//
// A transaction with a nonzero result runs through the multiply states, a setup
// state, a binary gcd, and two divisions through one shared restoring divider.
// A zero result or a zero result denominator skips the gcd and the divisions.
// Reset is synchronous and active high; it returns the sequencer to idle.
// The block takes no request while a transaction is in work or its result waits.
// A stalled result holds in the output register until it is taken.
module rational_fraction_alu_unit #(
   parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   rfa_req_if.sink   req,
   rfa_rsp_if.source rsp
);
   // Products need two operand widths; this is the working width.
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int SW = $clog2(PW + 1);

   rfa_pkg::state_type state_ff, state_in;

   logic [1:0]                  act_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff, bn_ff;
   logic [OPERAND_WIDTH-2:0]    ad_ff, bd_ff;

   // One shared signed multiplier, one product per cycle.
   logic signed [OPERAND_WIDTH:0] mul_x, mul_y;
   logic signed [PW+1:0]          mul_p;
   logic signed [PW+1:0]          p1_ff, p1_in, num_ff, num_in;
   logic signed [PW+1:0]          den_ff, den_in;

   // Magnitudes and gcd working values.
   logic [PW:0]  nm_ff, nm_in, dm_ff, dm_in;
   logic [PW:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic [SW:0]  sh_ff, sh_in;
   logic [PW:0]  g_ff, g_in;
   logic         neg_ff, neg_in;

   // Output register.
   logic                       ovalid_ff, ovalid_in;
   logic [rfa_pkg::RES_NUM_WIDTH-1:0] onum_ff, onum_in;
   logic [rfa_pkg::RES_DEN_WIDTH-1:0] oden_ff, oden_in;
   logic                       ost_ff, ost_in;

   // Divider sharing.
   logic        div_start, div_done;
   logic [PW:0] div_a, div_q;
   logic [PW:0] qn_ff, qn_in;
   logic [PW:0] rn;

   rfa_divider #(.N(PW + 1)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(g_ff), .quotient(div_q), .done(div_done)
   );
   assign div_a = (state_ff == rfa_pkg::ST_DIVN_START) ? nm_ff : dm_ff;

   assign mul_p = (PW + 2)'(mul_x * mul_y);

   always_comb begin
      mul_x = {an_ff[OPERAND_WIDTH-1], an_ff};
      mul_y = $signed({2'b00, bd_ff});
      case (state_ff)
         rfa_pkg::ST_MUL1: begin
            mul_x = {an_ff[OPERAND_WIDTH-1], an_ff};
            mul_y = (act_ff == rfa_pkg::ACT_MUL) ? {bn_ff[OPERAND_WIDTH-1], bn_ff}
                                                 : $signed({2'b00, bd_ff});
         end
         rfa_pkg::ST_MUL2: begin
            mul_x = $signed({2'b00, ad_ff});
            mul_y = {bn_ff[OPERAND_WIDTH-1], bn_ff};
         end
         rfa_pkg::ST_MUL3: begin
            mul_x = $signed({2'b00, ad_ff});
            mul_y = $signed({2'b00, bd_ff});
         end
         default: ;
      endcase
   end

   assign rn = neg_ff ? (~qn_ff + 1'b1) : qn_ff;

   always_comb begin
      state_in  = state_ff;
      p1_in     = p1_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      nm_in     = nm_ff;
      dm_in     = dm_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      sh_in     = sh_ff;
      g_in      = g_ff;
      neg_in    = neg_ff;
      qn_in     = qn_ff;
      ovalid_in = ovalid_ff;
      onum_in   = onum_ff;
      oden_in   = oden_ff;
      ost_in    = ost_ff;
      div_start = 1'b0;
      req.ready = (state_ff == rfa_pkg::ST_IDLE) && !ovalid_ff;
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      case (state_ff)
         rfa_pkg::ST_IDLE: begin
            if (req.valid && req.ready) state_in = rfa_pkg::ST_MUL1;
         end
         rfa_pkg::ST_MUL1: begin
            p1_in    = mul_p;
            state_in = rfa_pkg::ST_MUL2;
         end
         rfa_pkg::ST_MUL2: begin
            // Second product: ad*bn is the divide denominator or a cross term; multiply drops it.
            case (act_ff)
               rfa_pkg::ACT_ADD: num_in = p1_ff + mul_p;
               rfa_pkg::ACT_SUB: num_in = p1_ff - mul_p;
               rfa_pkg::ACT_MUL: num_in = p1_ff;
               default: begin
                  num_in = p1_ff;
                  den_in = mul_p;
               end
            endcase
            state_in = rfa_pkg::ST_MUL3;
         end
         rfa_pkg::ST_MUL3: begin
            if (act_ff != rfa_pkg::ACT_DIV) den_in = mul_p;
            state_in = rfa_pkg::ST_SETUP;
         end
         rfa_pkg::ST_SETUP: begin
            neg_in = num_ff[PW+1] ^ den_ff[PW+1];
            nm_in  = num_ff[PW+1] ? (PW+1)'(-num_ff) : (PW+1)'(num_ff);
            dm_in  = den_ff[PW+1] ? (PW+1)'(-den_ff) : (PW+1)'(den_ff);
            gx_in  = nm_in;
            gy_in  = dm_in;
            sh_in  = '0;
            if (den_ff == '0) begin
               onum_in   = '0;
               oden_in   = rfa_pkg::RES_DEN_WIDTH'(1);
               ost_in    = 1'b1;
               state_in  = rfa_pkg::ST_DONE;
            end else if (num_ff == '0) begin
               onum_in   = '0;
               oden_in   = rfa_pkg::RES_DEN_WIDTH'(1);
               ost_in    = 1'b0;
               state_in  = rfa_pkg::ST_DONE;
            end else begin
               state_in  = rfa_pkg::ST_GCD;
            end
         end
         rfa_pkg::ST_GCD: begin
            // Binary gcd, one step per cycle.
            if (gx_ff == gy_ff) begin
               g_in     = gx_ff << sh_ff;
               state_in = rfa_pkg::ST_DIVN_START;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               sh_in = sh_ff + 1'b1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff > gy_ff) begin
               gx_in = (gx_ff - gy_ff) >> 1;
            end else begin
               gy_in = (gy_ff - gx_ff) >> 1;
            end
         end
         rfa_pkg::ST_DIVN_START: begin
            div_start = 1'b1;
            state_in  = rfa_pkg::ST_DIVN_WAIT;
         end
         rfa_pkg::ST_DIVN_WAIT: begin
            if (div_done) begin
               qn_in    = div_q;
               state_in = rfa_pkg::ST_DIVD_START;
            end
         end
         rfa_pkg::ST_DIVD_START: begin
            div_start = 1'b1;
            state_in  = rfa_pkg::ST_DIVD_WAIT;
         end
         rfa_pkg::ST_DIVD_WAIT: begin
            if (div_done) begin
               onum_in  = rfa_pkg::RES_NUM_WIDTH'(rn);
               oden_in  = rfa_pkg::RES_DEN_WIDTH'(div_q);
               ost_in   = 1'b0;
               state_in = rfa_pkg::ST_DONE;
            end
         end
         rfa_pkg::ST_DONE: begin
            ovalid_in = 1'b1;
            state_in  = rfa_pkg::ST_IDLE;
         end
         default: state_in = rfa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rfa_pkg::ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      if (req.valid && req.ready) begin
         act_ff <= req.action;
         an_ff  <= req.a_num;
         ad_ff  <= req.a_den;
         bn_ff  <= req.b_num;
         bd_ff  <= req.b_den;
      end
      p1_ff   <= p1_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      sh_ff   <= sh_in;
      g_ff    <= g_in;
      neg_ff  <= neg_in;
      qn_ff   <= qn_in;
      onum_ff <= onum_in;
      oden_ff <= oden_in;
      ost_ff  <= ost_in;
   end

   assign rsp.valid   = ovalid_ff;
   assign rsp.res_num = onum_ff;
   assign rsp.res_den = oden_ff;
   assign rsp.status  = ost_ff;
endmodule

// ===== design/rfa_checker.sv =====
module rfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_res_num,
   input logic [29:0] rsp_res_den,
   input logic        rsp_status
);
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
   a_noready_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result waits");
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_res_den != 30'd0)) else $error("zero denominator");
   a_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_res_num == 32'd0 && rsp_res_den == 30'd1))
      else $error("error result not 0/1");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_res_num)))
      else $error("result dropped");
endmodule

bind rational_fraction_alu_unit rfa_checker u_rfa_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_res_num(rsp.res_num), .rsp_res_den(rsp.res_den), .rsp_status(rsp.status)
);

// ===== verif/tb_rational_fraction_alu_unit.sv =====
module tb_rational_fraction_alu_unit;

   localparam int W = rfa_pkg::OPERAND_WIDTH_DEFAULT;
   localparam int NW = rfa_pkg::RES_NUM_WIDTH;
   localparam int DW = rfa_pkg::RES_DEN_WIDTH;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;

   // One pair of fractions with the operation to apply to them.
   typedef struct {
      rfa_pkg::action_type act;
      logic signed [W-1:0] a_num;
      logic [W-2:0] a_den;
      logic signed [W-1:0] b_num;
      logic [W-2:0] b_den;
   } fraction_pair_type;

   // One reduced fraction as the block should return it.
   typedef struct {
      logic signed [NW-1:0] res_num;
      logic [DW-1:0] res_den;
      logic status;
   } reduced_fraction_type;

   // Keeps the reduced fractions still owed by the block, oldest first.
   class fraction_scoreboard;
      reduced_fraction_type owed[$];
      int errors = 0;

      function reduced_fraction_type reduce_pair(fraction_pair_type p);
         reduced_fraction_type r;
         longint an, ad, bn, bd, num, den;
         longint unsigned nm, dm, x, y, t;
         bit neg;
         an = longint'(p.a_num);
         bn = longint'(p.b_num);
         ad = longint'({1'b0, p.a_den});
         bd = longint'({1'b0, p.b_den});
         case (p.act)
            rfa_pkg::ACT_ADD: begin
               num = an * bd + ad * bn;
               den = ad * bd;
            end
            rfa_pkg::ACT_SUB: begin
               num = an * bd - ad * bn;
               den = ad * bd;
            end
            rfa_pkg::ACT_MUL: begin
               num = an * bn;
               den = ad * bd;
            end
            default: begin
               num = an * bd;
               den = ad * bn;
            end
         endcase
         if (den == 0) begin
            r.res_num = '0;
            r.res_den = DW'(1);
            r.status = 1'b1;
            return r;
         end
         neg = (num < 0) != (den < 0);
         nm = (num < 0) ? longint'(-num) : num;
         dm = (den < 0) ? longint'(-den) : den;
         x = nm;
         y = dm;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         nm = nm / x;
         dm = dm / x;
         if (nm == 0) begin
            neg = 1'b0;
            dm = 1;
         end
         r.res_num = NW'(neg ? -nm : nm);
         r.res_den = dm[DW-1:0];
         r.status = 1'b0;
         return r;
      endfunction

      function void note_request(fraction_pair_type p);
         owed.push_back(reduce_pair(p));
      endfunction

      function void check_result(reduced_fraction_type got);
         reduced_fraction_type want;
         if (owed.size() == 0) begin
            $error("result %0d/%0d status %0d arrived with nothing owed",
                   got.res_num, got.res_den, got.status);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.res_num !== want.res_num) begin
            $error("res_num: expected %0d, actual %0d", want.res_num, got.res_num);
            errors++;
         end
         if (got.res_den !== want.res_den) begin
            $error("res_den: expected %0d, actual %0d", want.res_den, got.res_den);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int cycle_count = 0;
   fraction_scoreboard board = new();

   rfa_req_if #(.W(W)) req_ch ();
   rfa_rsp_if rsp_ch ();

   rational_fraction_alu_unit #(.OPERAND_WIDTH(W)) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   // Free-running clock with a period of 4 time units.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Every input starts at a known value so nothing floats during reset.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = rfa_pkg::ACT_ADD;
      req_ch.a_num = '0;
      req_ch.a_den = (W-1)'(1);
      req_ch.b_num = '0;
      req_ch.b_den = (W-1)'(1);
      rsp_ch.ready = 1'b0;
   end

   // Watchdog: a hung block ends the run instead of spinning forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL rational_fraction_alu_unit");
         $finish;
      end
   end

   // The receiver alternates between windows of full throughput and windows in
   // which it stalls at random, so back pressure lands on every phase of the
   // block's sequencer, including results that have just appeared.
   int stall_window = 0;
   bit stall_mode = 1'b0;
   int stall_odds = 50;

   always @(posedge clock) begin
      reduced_fraction_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.res_num = rsp_ch.res_num;
            got.res_den = rsp_ch.res_den;
            got.status = rsp_ch.status;
            board.check_result(got);
         end
         if (stall_window == 0) begin
            stall_window <= $urandom_range(20, 300);
            stall_mode <= 1'($urandom_range(0, 1));
            stall_odds <= $urandom_range(10, 90);
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_window <= stall_window - 1;
            rsp_ch.ready <= stall_mode ? ($urandom_range(0, 99) >= stall_odds) : 1'b1;
         end
      end
   end

   // Presents one request and holds it until the block takes it. The
   // transaction is recorded at the edge where valid and ready were both high.
   task automatic drive_request(fraction_pair_type p);
      req_ch.valid <= 1'b1;
      req_ch.action <= p.act;
      req_ch.a_num <= p.a_num;
      req_ch.a_den <= p.a_den;
      req_ch.b_num <= p.b_num;
      req_ch.b_den <= p.b_den;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(p);
   endtask

   // Drops valid for a number of cycles between bursts.
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic fraction_pair_type make_pair(rfa_pkg::action_type act, int an,
                                                   int ad, int bn, int bd);
      fraction_pair_type p;
      p.act = act;
      p.a_num = W'(an);
      p.a_den = (W-1)'(ad);
      p.b_num = W'(bn);
      p.b_den = (W-1)'(bd);
      return p;
   endfunction

   // Mostly well-formed operands with random content. Small magnitudes are
   // favored now and then so that results reduce by a large common factor,
   // and a zero denominator slips in rarely to cover the out-of-range path.
   function automatic fraction_pair_type random_pair();
      fraction_pair_type p;
      int flavor;
      flavor = $urandom_range(0, 99);
      p.act = rfa_pkg::action_type'($urandom_range(0, 3));
      if (flavor < 25) begin
         p.a_num = W'(int'($urandom_range(0, 40)) - 20);
         p.b_num = W'(int'($urandom_range(0, 40)) - 20);
         p.a_den = (W-1)'($urandom_range(1, 24));
         p.b_den = (W-1)'($urandom_range(1, 24));
      end else begin
         p.a_num = W'($urandom());
         p.b_num = W'($urandom());
         p.a_den = (W-1)'($urandom_range(1, 32767));
         p.b_den = (W-1)'($urandom_range(1, 32767));
      end
      if (flavor >= 95) p.a_den = '0;
      else if (flavor >= 90) p.b_den = '0;
      else if (flavor >= 85) p.b_num = '0;
      return p;
   endfunction

   fraction_pair_type directed[$];

   initial begin
      int burst_left;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes under each operation, a zero result,
      // division by a zero fraction, and zero operand denominators.
      directed.push_back(make_pair(rfa_pkg::ACT_ADD, 32767, 1, 32767, 1));
      directed.push_back(make_pair(rfa_pkg::ACT_ADD, -32768, 32767, -32768, 32767));
      directed.push_back(make_pair(rfa_pkg::ACT_SUB, 32767, 1, -32768, 1));
      directed.push_back(make_pair(rfa_pkg::ACT_SUB, -32768, 1, 32767, 32767));
      directed.push_back(make_pair(rfa_pkg::ACT_MUL, -32768, 1, -32768, 1));
      directed.push_back(make_pair(rfa_pkg::ACT_MUL, 32767, 32767, -32768, 32767));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, -32768, 1, 1, 32767));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, 32767, 32767, -32768, 1));
      directed.push_back(make_pair(rfa_pkg::ACT_SUB, 7, 3, 7, 3));
      directed.push_back(make_pair(rfa_pkg::ACT_ADD, 5, 9, -5, 9));
      directed.push_back(make_pair(rfa_pkg::ACT_MUL, 0, 12, 99, 7));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, 0, 5, -3, 4));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, 4, 6, 0, 8));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, -32768, 32767, 0, 32767));
      directed.push_back(make_pair(rfa_pkg::ACT_ADD, 3, 0, 4, 5));
      directed.push_back(make_pair(rfa_pkg::ACT_MUL, 3, 4, 5, 0));
      directed.push_back(make_pair(rfa_pkg::ACT_SUB, 0, 0, 0, 0));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, 6, 0, 2, 3));
      directed.push_back(make_pair(rfa_pkg::ACT_DIV, 6, 4, -2, 3));
      directed.push_back(make_pair(rfa_pkg::ACT_MUL, 6, 4, 10, 15));
      directed.push_back(make_pair(rfa_pkg::ACT_ADD, 1, 2, 1, 2));
      foreach (directed[i]) drive_request(directed[i]);

      // Random part in bursts of random length with random gaps between them;
      // some bursts run back to back with no gap at all.
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
         end
         drive_request(random_pair());
         burst_left--;
      end
      req_ch.valid <= 1'b0;

      // Drain: wait for every owed result, then a little longer so a stray
      // extra result would still be caught.
      while (board.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("PASS rational_fraction_alu_unit");
      end else begin
         $display("FAIL rational_fraction_alu_unit");
      end
      $finish;
   end

endmodule

// ===== rational_fraction_alu_unit.f =====
design/rfa_pkg.sv
design/rfa_if.sv
design/rfa_divider.sv
design/rational_fraction_alu_unit.sv
design/rfa_checker.sv
verif/tb_rational_fraction_alu_unit.sv
